>>> design/rto_estimator_assert.svh
// Assertion macros for the RTO estimator block.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef RTO_ESTIMATOR_ASSERT_SVH
`define RTO_ESTIMATOR_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define RTO_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that cons holds in the cycle after ante.
`define RTO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/rto_pkg.sv
// Shared types and constants for the RTO estimator.
// Used by rto_update and rto_estimator; depends on nothing.
package rto_pkg;

	localparam int FRAC_BITS = 8;
	localparam int MS_W = 16;
	localparam int STATE_W = MS_W + FRAC_BITS;
	localparam int TIMEOUT_W = 19;
	localparam int MODE_W = 2;
	localparam int CFG_INDEX_W = 1;

	localparam logic [STATE_W-1:0] SRTT_RESET = 24'd256000;
	localparam logic [STATE_W-1:0] DEV_RESET = '0;
	localparam logic [MS_W-1:0] BACKOFF_FLOOR_RESET = 16'd30;
	localparam logic [MS_W-1:0] MARGIN_FLOOR_RESET = 16'd30;

	localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_FLOOR = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MARGIN_FLOOR = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_BACKOFF = 2'd1,
		MODE_QUERY = 2'd2
	} mode_t;

	typedef struct packed {
		logic [STATE_W-1:0] srtt;
		logic [STATE_W-1:0] dev;
	} rto_state_t;

endpackage

>>> design/rto_update.sv
// Next-state and timeout logic for one word of the RTO estimator.
// Purely combinational; depends on rto_pkg.
module rto_update (
	input  logic [rto_pkg::MODE_W-1:0]    mode,
	input  logic [rto_pkg::MS_W-1:0]      rtt_ms,
	input  rto_pkg::rto_state_t           state_cur,
	input  logic [rto_pkg::MS_W-1:0]      backoff_floor,
	input  logic [rto_pkg::MS_W-1:0]      margin_floor,
	output rto_pkg::rto_state_t           state_next,
	output logic [rto_pkg::TIMEOUT_W-1:0] timeout_next
);

	localparam int SW = rto_pkg::STATE_W;
	localparam int FB = rto_pkg::FRAC_BITS;

	logic [SW-1:0] sample;
	logic [SW-1:0] err;
	logic [SW+1:0] dev_sum;
	logic [SW+2:0] srtt_sum;
	logic [SW:0]   doubled;
	logic [SW-1:0] bo_floor;
	logic [SW:0]   bo_val;
	logic [SW+1:0] four_dev;
	logic [SW+1:0] margin;
	logic [SW+1:0] add_term;
	logic [SW+2:0] total;

	always_comb begin
		sample = {rtt_ms, {FB{1'b0}}};
		err = (state_cur.srtt >= sample) ? (state_cur.srtt - sample) : (sample - state_cur.srtt);
		dev_sum = {1'b0, state_cur.dev, 1'b0} + {2'b00, state_cur.dev} + {2'b00, err};
		srtt_sum = {state_cur.srtt, 3'b000} - {3'b000, state_cur.srtt} + {3'b000, sample};

		doubled = {state_cur.srtt, 1'b0};
		bo_floor = {backoff_floor, {FB{1'b0}}};
		bo_val = (doubled > {1'b0, bo_floor}) ? doubled : {1'b0, bo_floor};

		state_next = state_cur;
		unique case (mode)
			rto_pkg::MODE_SAMPLE: begin
				state_next.dev = dev_sum[SW+1:2];
				state_next.srtt = srtt_sum[SW+2:3];
			end
			rto_pkg::MODE_BACKOFF: begin
				state_next.srtt = bo_val[SW] ? {SW{1'b1}} : bo_val[SW-1:0];
			end
			default: begin
				state_next = state_cur;
			end
		endcase

		four_dev = {state_next.dev, 2'b00};
		margin = {2'b00, margin_floor, {FB{1'b0}}};
		add_term = (four_dev > margin) ? four_dev : margin;
		total = {3'b000, state_next.srtt} + {1'b0, add_term};
		timeout_next = total[SW+2:FB];
	end

endmodule

>>> design/rto_estimator.sv
// The timeout word is loaded into the output register at the accepting edge.
// Throughput: one word per cycle while the output is not stalled; the update and timeout form one combinational pass.
// Input is taken whenever the output register is empty or is emptied in the same cycle.
// Reset: smoothed time 1000 ms, deviation zero, both floors 30 ms, output register empty.
// Top level of the RTO estimator; depends on rto_pkg, rto_update and
// rto_estimator_assert.svh.
module rto_estimator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rto_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [rto_pkg::MS_W-1:0]              cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [rto_pkg::MODE_W-1:0]            mode,
	input  logic [rto_pkg::MS_W-1:0]              rtt_ms,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [rto_pkg::TIMEOUT_W-1:0]         timeout_ms
);

	logic [rto_pkg::MS_W-1:0] backoff_floor_q;
	logic [rto_pkg::MS_W-1:0] margin_floor_q;
	rto_pkg::rto_state_t state_q;
	rto_pkg::rto_state_t state_next;
	logic [rto_pkg::TIMEOUT_W-1:0] timeout_next;
	logic [rto_pkg::TIMEOUT_W-1:0] timeout_q;
	logic out_valid_q;
	logic in_accept;

	assign in_ready = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign timeout_ms = timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backoff_floor_q <= rto_pkg::BACKOFF_FLOOR_RESET;
			margin_floor_q <= rto_pkg::MARGIN_FLOOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rto_pkg::REG_BACKOFF_FLOOR: backoff_floor_q <= cfg_wdata;
				rto_pkg::REG_MARGIN_FLOOR: margin_floor_q <= cfg_wdata;
				default: backoff_floor_q <= backoff_floor_q;
			endcase
		end
	end

	rto_update u_update (
		.mode          (mode),
		.rtt_ms        (rtt_ms),
		.state_cur     (state_q),
		.backoff_floor (backoff_floor_q),
		.margin_floor  (margin_floor_q),
		.state_next    (state_next),
		.timeout_next  (timeout_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.srtt <= rto_pkg::SRTT_RESET;
			state_q.dev <= rto_pkg::DEV_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				state_q <= state_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			timeout_q <= timeout_next;
		end
	end

`include "rto_estimator_assert.svh"

	`RTO_ASSERT_SAME(a_stall_blocks_input, out_valid_q && !out_ready, !in_ready, "input in stall")
	`RTO_ASSERT_NEXT(a_accept_fills_output, in_accept, out_valid_q, "accepted word lost")
	`RTO_ASSERT_NEXT(a_state_holds, !in_accept, $stable(state_q), "state changed when idle")

endmodule
